// ----- hdl/hsl_pkg.sv -----
package hsl_pkg;

  // internal fixed-point format: unsigned Q1.FRAC_BITS
  localparam int FRAC_BITS = 16;
  localparam int VW        = FRAC_BITS + 1;   // Q1.F value width
  localparam int HW        = FRAC_BITS;       // hue position width
  localparam int RW        = FRAC_BITS + 2;   // ramp output, may pass 1.0 slightly
  localparam int PW        = VW + HW;         // diff * x product width
  localparam int NCH       = 3;               // red, green, blue

  // port field widths
  localparam int IN_HW  = 16;
  localparam int IN_LW  = 17;
  localparam int OUT_CW = 8;

  localparam logic [IN_LW-1:0] IN_ONE = {1'b1, {(IN_LW-1){1'b0}}};

  localparam logic [VW-1:0] ONE_FX  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [VW-1:0] HALF_FX = ONE_FX >> 1;

  localparam int THIRD_I      = ((1 << FRAC_BITS) + 1) / 3;
  localparam int TWO_THIRDS_I = ((2 << FRAC_BITS) + 1) / 3;

  localparam logic [HW-1:0] THIRD_FX      = HW'(THIRD_I);
  localparam logic [HW-1:0] NEG_THIRD_FX  = HW'((1 << FRAC_BITS) - THIRD_I);
  localparam logic [HW-1:0] TWO_THIRDS_FX = HW'(TWO_THIRDS_I);

  // rescale a 16-bit fraction to FRAC_BITS
  localparam int CONV_W = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 1;
  localparam int CONV_L = (FRAC_BITS >= 16) ? (FRAC_BITS - 16) : 0;
  localparam int CONV_R = (FRAC_BITS >= 16) ? 0 : (16 - FRAC_BITS);

  // segment of the piecewise hue function
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  // per-channel work item between the mix and ramp stages
  typedef struct packed {
    logic [VW-1:0] m1;
    logic [VW-1:0] diff;
    seg_t          seg;
    logic [HW-1:0] x;
  } chan_t;

  function automatic logic [VW-1:0] from16(input logic [IN_LW-1:0] v);
    logic [CONV_W-1:0] w;
    w = CONV_W'(v);
    w = (w << CONV_L) >> CONV_R;
    return w[VW-1:0];
  endfunction

endpackage

// ----- hdl/hsl_if.sv -----
// hsl input beat
interface hsl_in_if import hsl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IN_HW-1:0] hue;
  logic [IN_LW-1:0] lightness;
  logic [IN_LW-1:0] saturation;

  modport source (output valid, output hue, output lightness, output saturation,
                  input ready);
  modport sink   (input valid, input hue, input lightness, input saturation,
                  output ready);
endinterface

// rgb output beat
interface hsl_out_if import hsl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OUT_CW-1:0] red;
  logic [OUT_CW-1:0] green;
  logic [OUT_CW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- hdl/hsl_mix.sv -----
module hsl_mix import hsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [IN_HW-1:0]      hue,
  input  logic [IN_LW-1:0]      lightness,
  input  logic [IN_LW-1:0]      saturation,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output chan_t [NCH-1:0]       chan
);

  logic                  v1_r, v2_r;
  logic                  en1, en2;
  logic [VW-1:0]         l1_r, s1_r, l1_nxt, s1_nxt;
  logic [2*VW-1:0]       p1_r, p1_nxt;
  logic [NCH-1:0][HW-1:0] h1_r, h1_nxt;
  chan_t [NCH-1:0]       chan2_r, chan2_nxt;

  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;
  assign dn_valid = v2_r;
  assign chan     = chan2_r;

  // stage 1: clamp, rescale, hue positions, l*s product
  always_comb begin
    logic [IN_LW-1:0] l_c, s_c;
    logic [VW-1:0]    h_w;
    l_c = (lightness > IN_ONE) ? IN_ONE : lightness;
    s_c = (saturation > IN_ONE) ? IN_ONE : saturation;
    l1_nxt = from16(l_c);
    s1_nxt = from16(s_c);
    h_w = from16({1'b0, hue});
    h1_nxt[0] = h_w[HW-1:0] + THIRD_FX;
    h1_nxt[1] = h_w[HW-1:0];
    h1_nxt[2] = h_w[HW-1:0] + NEG_THIRD_FX;
    p1_nxt = (2*VW)'(l1_nxt) * (2*VW)'(s1_nxt);
  end

  // stage 2: m1, m2 and segment of each channel
  always_comb begin
    logic [VW-1:0]   ls;
    logic [VW:0]     m2_w, m1_w;
    logic [VW-1:0]   diff;
    logic [HW+2:0]   h_e, one_e;
    ls   = p1_r[FRAC_BITS +: VW];
    m2_w = (l1_r <= HALF_FX) ? ({1'b0, l1_r} + {1'b0, ls})
                             : ({1'b0, l1_r} + {1'b0, s1_r} - {1'b0, ls});
    m1_w = {l1_r, 1'b0} - m2_w;
    diff = m2_w[VW-1:0] - m1_w[VW-1:0];
    one_e = (HW+3)'(ONE_FX);
    for (int k = 0; k < NCH; k++) begin
      h_e = (HW+3)'(h1_r[k]);
      chan2_nxt[k].m1   = m1_w[VW-1:0];
      chan2_nxt[k].diff = diff;
      if ((h_e * (HW+3)'(6)) < one_e) begin
        chan2_nxt[k].seg = SEG_RISE;
        chan2_nxt[k].x   = h1_r[k];
      end else if ((h_e << 1) < one_e) begin
        chan2_nxt[k].seg = SEG_HIGH;
        chan2_nxt[k].x   = '0;
      end else if ((h_e * (HW+3)'(3)) < (one_e << 1)) begin
        chan2_nxt[k].seg = SEG_FALL;
        chan2_nxt[k].x   = (TWO_THIRDS_FX > h1_r[k]) ? (TWO_THIRDS_FX - h1_r[k]) : '0;
      end else begin
        chan2_nxt[k].seg = SEG_LOW;
        chan2_nxt[k].x   = '0;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en1 && up_valid) begin
      l1_r <= l1_nxt;
      s1_r <= s1_nxt;
      p1_r <= p1_nxt;
      h1_r <= h1_nxt;
    end
    if (en2 && v1_r) begin
      chan2_r <= chan2_nxt;
    end
  end

  // truncated l*s never exceeds l
  a_ls_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (p1_r[FRAC_BITS +: VW] <= l1_r))
    else $error("l*s product above lightness");

  // m2 = m1 + diff stays within one
  a_m2_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (({1'b0, chan2_r[0].m1} + {1'b0, chan2_r[0].diff}) <= {1'b0, ONE_FX}))
    else $error("m2 above one");

endmodule

// ----- hdl/hsl_ramp.sv -----
module hsl_ramp import hsl_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  chan_t [NCH-1:0]        chan,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [NCH-1:0][RW-1:0] val
);

  logic                   v3_r, v4_r;
  logic                   en3, en4;
  logic [NCH-1:0][PW-1:0] prod3_r, prod3_nxt;
  logic [NCH-1:0][VW-1:0] m13_r, diff3_r;
  seg_t [NCH-1:0]         seg3_r;
  logic [NCH-1:0][RW-1:0] val4_r, val4_nxt;

  assign en4      = !v4_r || dn_ready;
  assign en3      = !v3_r || en4;
  assign up_ready = en3;
  assign dn_valid = v4_r;
  assign val      = val4_r;

  // stage 3: ramp product per channel
  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      prod3_nxt[k] = PW'(chan[k].diff) * PW'(chan[k].x);
    end
  end

  // stage 4: scale by six and pick the segment value
  always_comb begin
    logic [PW+2:0] t6;
    logic [RW-1:0] term;
    for (int k = 0; k < NCH; k++) begin
      t6   = ((PW+3)'(prod3_r[k]) << 2) + ((PW+3)'(prod3_r[k]) << 1);
      term = t6[FRAC_BITS +: RW];
      case (seg3_r[k])
        SEG_RISE: val4_nxt[k] = RW'(m13_r[k]) + term;
        SEG_HIGH: val4_nxt[k] = RW'(m13_r[k]) + RW'(diff3_r[k]);
        SEG_FALL: val4_nxt[k] = RW'(m13_r[k]) + term;
        SEG_LOW:  val4_nxt[k] = RW'(m13_r[k]);
        default:  val4_nxt[k] = RW'(m13_r[k]);
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en3) v3_r <= up_valid;
      if (en4) v4_r <= v3_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en3 && up_valid) begin
      prod3_r <= prod3_nxt;
      for (int k = 0; k < NCH; k++) begin
        m13_r[k]   <= chan[k].m1;
        diff3_r[k] <= chan[k].diff;
        seg3_r[k]  <= chan[k].seg;
      end
    end
    if (en4 && v3_r) begin
      val4_r <= val4_nxt;
    end
  end

  // ramp output overshoots one by at most two lsb (falling edge with x of a full sixth)
  a_val_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (val4_r[1] <= (RW'(ONE_FX) + RW'(2))))
    else $error("channel value out of range");

endmodule

// ----- hdl/hsl_quant.sv -----
module hsl_quant import hsl_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       up_valid,
  output logic                       up_ready,
  input  logic [NCH-1:0][RW-1:0]     val,
  output logic                       dn_valid,
  input  logic                       dn_ready,
  output logic [NCH-1:0][OUT_CW-1:0] rgb
);

  localparam int CW = RW + 8 - FRAC_BITS;

  logic                       v5_r;
  logic                       en5;
  logic [NCH-1:0][OUT_CW-1:0] rgb5_r, rgb5_nxt;

  assign en5      = !v5_r || dn_ready;
  assign up_ready = en5;
  assign dn_valid = v5_r;
  assign rgb      = rgb5_r;

  // value * 255, truncated and saturated
  always_comb begin
    logic [RW+7:0] v255;
    logic [CW-1:0] c;
    for (int k = 0; k < NCH; k++) begin
      v255 = {val[k], 8'b0} - (RW+8)'(val[k]);
      c    = v255[FRAC_BITS +: CW];
      rgb5_nxt[k] = (c > CW'(255)) ? {OUT_CW{1'b1}} : c[OUT_CW-1:0];
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en5) begin
      v5_r <= up_valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (en5 && up_valid) begin
      rgb5_r <= rgb5_nxt;
    end
  end

  // a stalled result is held unchanged
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !dn_ready |=> v5_r && $stable(rgb5_r))
    else $error("stalled result changed");

endmodule

// ----- hdl/hsl_to_rgb_converter.sv -----
// hsl to rgb converter: five register stages between input beat and output beat
// throughput one beat per clock when the output side does not stall; each stage
// holds at most one multiplier (l*s, then diff*x per channel), the output stage
// is the last register; reset (rst_n low, synchronous) clears only the valid
// bits; the payload registers are not reset and there is no clearing pass
module hsl_to_rgb_converter import hsl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hsl_in_if.sink    in_ch,
  hsl_out_if.source out_ch
);

  logic                       mix_valid, mix_ready;
  chan_t [NCH-1:0]            mix_chan;
  logic                       ramp_valid, ramp_ready;
  logic [NCH-1:0][RW-1:0]     ramp_val;
  logic [NCH-1:0][OUT_CW-1:0] rgb;

  // lightness/saturation mix and hue segment
  hsl_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_ch.valid),
    .up_ready   (in_ch.ready),
    .hue        (in_ch.hue),
    .lightness  (in_ch.lightness),
    .saturation (in_ch.saturation),
    .dn_valid   (mix_valid),
    .dn_ready   (mix_ready),
    .chan       (mix_chan)
  );

  // piecewise hue ramps
  hsl_ramp u_ramp (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mix_valid),
    .up_ready (mix_ready),
    .chan     (mix_chan),
    .dn_valid (ramp_valid),
    .dn_ready (ramp_ready),
    .val      (ramp_val)
  );

  // 8-bit quantization and output register
  hsl_quant u_quant (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (ramp_valid),
    .up_ready (ramp_ready),
    .val      (ramp_val),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .rgb      (rgb)
  );

  assign out_ch.red   = rgb[0];
  assign out_ch.green = rgb[1];
  assign out_ch.blue  = rgb[2];

endmodule
